// ===== src/hmcd_pkg.sv =====
package hmcd_pkg;

    localparam int MAX_ROWS  = 128;
    localparam int MAX_COLS  = 128;
    localparam int MAX_REACH = 7;

    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int HEIGHT_W = 16;
    localparam int REACH_W  = 3;
    localparam int TOL_W    = 8;
    localparam int DIM_W    = 8;
    localparam int PROD_W   = TOL_W + HEIGHT_W;

    localparam logic [REACH_W-1:0] REACH_RESET = 3'd2;
    localparam logic [TOL_W-1:0]   TOL_RESET   = 8'd51;
    localparam logic [DIM_W-1:0]   ROWS_RESET  = 8'd128;
    localparam logic [DIM_W-1:0]   COLS_RESET  = 8'd128;

    localparam logic [1:0] CFG_WINDOW_REACH  = 2'd0;
    localparam logic [1:0] CFG_REL_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_GRID_ROWS     = 2'd2;
    localparam logic [1:0] CFG_GRID_COLS     = 2'd3;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    typedef struct packed {
        logic                       empty;
        logic signed [HEIGHT_W-1:0] height;
    } cell_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        cell_t             map_cell;
        cell_t             frame_cell;
    } mem_wr_t;

    typedef struct packed {
        logic              frame_en;
        logic [ADDR_W-1:0] frame_addr;
        logic              map_en;
        logic [ADDR_W-1:0] map_addr;
    } mem_rd_t;

endpackage

// ===== src/hmcd_grid_mem.sv =====
module hmcd_grid_mem (
    input  logic             aclk,
    input  hmcd_pkg::mem_wr_t wr,
    input  hmcd_pkg::mem_rd_t rd,
    output hmcd_pkg::cell_t  frame_rd_data,
    output hmcd_pkg::cell_t  map_rd_data
);

    localparam int DEPTH = hmcd_pkg::MAX_ROWS * hmcd_pkg::MAX_COLS;

    hmcd_pkg::cell_t map_mem   [DEPTH];
    hmcd_pkg::cell_t frame_mem [DEPTH];
    hmcd_pkg::cell_t frame_rd_reg;
    hmcd_pkg::cell_t map_rd_reg;

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            map_mem[wr.addr] <= wr.map_cell;
        end
        if (rd.map_en) begin
            map_rd_reg <= map_mem[rd.map_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            frame_mem[wr.addr] <= wr.frame_cell;
        end
        if (rd.frame_en) begin
            frame_rd_reg <= frame_mem[rd.frame_addr];
        end
    end

    assign frame_rd_data = frame_rd_reg;
    assign map_rd_data   = map_rd_reg;

endmodule

// ===== src/height_map_change_detect.sv =====
// height_map_change_detect: compares a new height frame against a stored map, cell by cell.
// s_ channel takes items; s_tuser is the kind: write (both grids at row/col) or query.
// a write is absorbed in the cycle it transfers; the next item can follow at once.
// a query produces one result on the m_ channel: moving flag and the smallest
// |map - new| over the clipped window of rows and columns around the cell.
// query steps: the new-frame cell is read, then one map read per window cell is issued
// on the single map memory read port (up to 16 cells at the default reach of 2), a drain
// state lets the last read return and a final state forms the result; the next item is
// taken once the result is registered. queries that fail the grid, occupancy (empty or
// zero-height new cell) or reach (reach 0) checks skip the scan. a finished result sits
// in an output register; while it waits the block accepts and works on the next item and
// only holds in its final cycle until m_tready frees it. cfg_ channel writes a register
// (0 reach, 1 tolerance, 2 rows, 3 cols); the user writes it only while idle, the block does not enforce this.
// reset (aresetn low, synchronous) restores register defaults and drops m_tvalid;
// grid contents are not cleared and a cell must be written before it is queried.
module height_map_change_detect (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // row[6:0], col[13:7], map_height[29:14], map_empty[30], new_height[46:31], new_empty[47]
    input  logic [47:0] s_tdata,
    // kind[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // moving[0], min_difference[16:1], zero fill [23:17]
    output logic [23:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int RW = hmcd_pkg::ROW_W;
    localparam int CW = hmcd_pkg::COL_W;
    localparam int HW = hmcd_pkg::HEIGHT_W;
    localparam int DW = hmcd_pkg::DIM_W;
    localparam int PW = hmcd_pkg::PROD_W;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CHECK = 5'b00010,
        ST_SCAN  = 5'b00100,
        ST_DRAIN = 5'b01000,
        ST_FIN   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [hmcd_pkg::REACH_W-1:0] reach_reg, reach_next;
    logic [hmcd_pkg::TOL_W-1:0]   tol_reg, tol_next;
    logic [DW-1:0]                rows_reg, rows_next;
    logic [DW-1:0]                cols_reg, cols_next;

    logic [DW-1:0] r_lo_reg, r_lo_next, r_hi_reg, r_hi_next;
    logic [DW-1:0] c_lo_reg, c_lo_next, c_hi_reg, c_hi_next;
    logic [DW-1:0] r_cnt_reg, r_cnt_next, c_cnt_reg, c_cnt_next;
    logic          out_grid_reg, out_grid_next;
    logic          win_empty_reg, win_empty_next;
    logic          zero_res_reg, zero_res_next;
    logic signed [HW-1:0] new_h_reg, new_h_next;
    logic [PW-1:0] prod_reg, prod_next;
    logic [HW-1:0] min_reg, min_next;
    logic          found_reg, found_next;
    logic          hit_empty_reg, hit_empty_next;
    logic          rd_vld_reg, rd_vld_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [23:0]   m_tdata_reg, m_tdata_next;

    hmcd_pkg::mem_wr_t mem_wr;
    hmcd_pkg::mem_rd_t mem_rd;
    hmcd_pkg::cell_t   frame_q;
    hmcd_pkg::cell_t   map_q;

    logic          s_transfer;
    logic [RW-1:0] in_row;
    logic [CW-1:0] in_col;
    logic [DW-1:0] in_row8, in_col8, reach8, rows_eff, cols_eff;
    logic [DW-1:0] r_sum, c_sum;
    logic [hmcd_pkg::REACH_W-1:0] reach_eff;
    logic signed [HW:0] diff;
    logic [HW-1:0] abs_diff;
    logic [HW-1:0] abs_new;
    logic          res_moving;
    logic [HW-1:0] res_diff;
    logic          c_last, r_last;

    hmcd_grid_mem u_mem (
        .aclk          (aclk),
        .wr            (mem_wr),
        .rd            (mem_rd),
        .frame_rd_data (frame_q),
        .map_rd_data   (map_q)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_transfer = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign in_row = s_tdata[RW-1:0];
    assign in_col = s_tdata[RW+CW-1:RW];
    assign in_row8 = DW'(in_row);
    assign in_col8 = DW'(in_col);

    assign rows_eff  = (rows_reg > DW'(hmcd_pkg::MAX_ROWS)) ? DW'(hmcd_pkg::MAX_ROWS) : rows_reg;
    assign cols_eff  = (cols_reg > DW'(hmcd_pkg::MAX_COLS)) ? DW'(hmcd_pkg::MAX_COLS) : cols_reg;
    assign reach_eff = (DW'(reach_reg) > DW'(hmcd_pkg::MAX_REACH)) ?
                       hmcd_pkg::REACH_W'(hmcd_pkg::MAX_REACH) : reach_reg;
    assign reach8 = DW'(reach_eff);
    assign r_sum  = in_row8 + reach8;
    assign c_sum  = in_col8 + reach8;

    assign diff     = {map_q.height[HW-1], map_q.height} - {new_h_reg[HW-1], new_h_reg};
    assign abs_diff = diff[HW] ? HW'(-diff) : diff[HW-1:0];
    assign abs_new  = frame_q.height[HW-1] ? HW'(-frame_q.height) : HW'(frame_q.height);

    assign c_last = (c_cnt_reg + DW'(1)) == c_hi_reg;
    assign r_last = (r_cnt_reg + DW'(1)) == r_hi_reg;

    always_comb begin
        if (zero_res_reg || hit_empty_reg) begin
            res_moving = 1'b0;
            res_diff   = '0;
        end else if (!found_reg) begin
            res_moving = 1'b1;
            res_diff   = '1;
        end else begin
            res_moving = {min_reg, 8'b0} >= prod_reg;
            res_diff   = min_reg;
        end
    end

    always_comb begin
        state_next     = state_reg;
        reach_next     = reach_reg;
        tol_next       = tol_reg;
        rows_next      = rows_reg;
        cols_next      = cols_reg;
        r_lo_next      = r_lo_reg;
        r_hi_next      = r_hi_reg;
        c_lo_next      = c_lo_reg;
        c_hi_next      = c_hi_reg;
        r_cnt_next     = r_cnt_reg;
        c_cnt_next     = c_cnt_reg;
        out_grid_next  = out_grid_reg;
        win_empty_next = win_empty_reg;
        zero_res_next  = zero_res_reg;
        new_h_next     = new_h_reg;
        prod_next      = prod_reg;
        min_next       = min_reg;
        found_next     = found_reg;
        hit_empty_next = hit_empty_reg;
        rd_vld_next    = 1'b0;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        mem_wr.en               = s_transfer && (s_tuser == hmcd_pkg::KIND_WRITE);
        mem_wr.addr             = {in_row, in_col};
        mem_wr.map_cell.height  = s_tdata[29:14];
        mem_wr.map_cell.empty   = s_tdata[30];
        mem_wr.frame_cell.height = s_tdata[46:31];
        mem_wr.frame_cell.empty = s_tdata[47];

        mem_rd.frame_en   = s_transfer && (s_tuser == hmcd_pkg::KIND_QUERY);
        mem_rd.frame_addr = {in_row, in_col};
        mem_rd.map_en     = 1'b0;
        mem_rd.map_addr   = {r_cnt_reg[RW-1:0], c_cnt_reg[CW-1:0]};

        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                hmcd_pkg::CFG_WINDOW_REACH:  reach_next = cfg_data[hmcd_pkg::REACH_W-1:0];
                hmcd_pkg::CFG_REL_TOLERANCE: tol_next   = cfg_data;
                hmcd_pkg::CFG_GRID_ROWS:     rows_next  = cfg_data;
                hmcd_pkg::CFG_GRID_COLS:     cols_next  = cfg_data;
            endcase
        end

        if (rd_vld_reg) begin
            if (map_q.empty) begin
                hit_empty_next = 1'b1;
            end else if (!found_reg || abs_diff < min_reg) begin
                min_next   = abs_diff;
                found_next = 1'b1;
            end else begin
                found_next = 1'b1;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_transfer && (s_tuser == hmcd_pkg::KIND_QUERY)) begin
                    r_lo_next      = (in_row8 >= reach8) ? (in_row8 - reach8) : '0;
                    c_lo_next      = (in_col8 >= reach8) ? (in_col8 - reach8) : '0;
                    r_hi_next      = (r_sum < rows_eff) ? r_sum : rows_eff;
                    c_hi_next      = (c_sum < cols_eff) ? c_sum : cols_eff;
                    out_grid_next  = (in_row8 >= rows_eff) || (in_col8 >= cols_eff);
                    win_empty_next = (reach_eff == '0);
                    state_next     = ST_CHECK;
                end
            end
            ST_CHECK: begin
                new_h_next     = frame_q.height;
                prod_next      = tol_reg * abs_new;
                zero_res_next  = out_grid_reg || frame_q.empty || (frame_q.height == '0);
                found_next     = 1'b0;
                hit_empty_next = 1'b0;
                r_cnt_next     = r_lo_reg;
                c_cnt_next     = c_lo_reg;
                if (out_grid_reg || frame_q.empty || (frame_q.height == '0) || win_empty_reg) begin
                    state_next = ST_FIN;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                mem_rd.map_en = 1'b1;
                rd_vld_next   = 1'b1;
                if (c_last) begin
                    c_cnt_next = c_lo_reg;
                    r_cnt_next = r_cnt_reg + DW'(1);
                    if (r_last) begin
                        state_next = ST_DRAIN;
                    end
                end else begin
                    c_cnt_next = c_cnt_reg + DW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {7'b0, res_diff, res_moving};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            reach_reg    <= hmcd_pkg::REACH_RESET;
            tol_reg      <= hmcd_pkg::TOL_RESET;
            rows_reg     <= hmcd_pkg::ROWS_RESET;
            cols_reg     <= hmcd_pkg::COLS_RESET;
            rd_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            reach_reg    <= reach_next;
            tol_reg      <= tol_next;
            rows_reg     <= rows_next;
            cols_reg     <= cols_next;
            rd_vld_reg   <= rd_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        r_lo_reg      <= r_lo_next;
        r_hi_reg      <= r_hi_next;
        c_lo_reg      <= c_lo_next;
        c_hi_reg      <= c_hi_next;
        r_cnt_reg     <= r_cnt_next;
        c_cnt_reg     <= c_cnt_next;
        out_grid_reg  <= out_grid_next;
        win_empty_reg <= win_empty_next;
        zero_res_reg  <= zero_res_next;
        new_h_reg     <= new_h_next;
        prod_reg      <= prod_next;
        min_reg       <= min_next;
        found_reg     <= found_next;
        hit_empty_reg <= hit_empty_next;
        m_tdata_reg   <= m_tdata_next;
    end

`ifndef SYNTH
    // the last map read of a scan returns while draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DRAIN) |-> rd_vld_reg)
        else $error("drain without returning map read");

    // map read data is only consumed in the cycle after a scan read
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> $past(state_reg == ST_SCAN))
        else $error("map read data without a scan read");

    // scan counters stay inside the clipped window
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> ((r_cnt_reg < r_hi_reg) && (c_cnt_reg < c_hi_reg)))
        else $error("scan address outside window");

    // a waiting result is never overwritten before its transfer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result lost");
`endif

endmodule
